/* sv/mbps_pkg.sv */
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared types, constants and helpers of the masked byte pattern scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package mbps_pkg;

  localparam int unsigned PATTERN_BYTES         = 16;
  localparam int unsigned MAX_PATTERN_BYTES_DEF = 16;
  localparam int unsigned ADDR_W                = 64;
  localparam int unsigned LEN_W                 = 5;
  localparam int unsigned CFG_IDX_W             = 3;
  localparam int unsigned BYTE_IDX_W            = $clog2(PATTERN_BYTES);

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_VALUE_LO = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VALUE_HI = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_LO  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_HI  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BASE     = 3'd5;

  // record kinds
  localparam logic KIND_MATCH = 1'b0;
  localparam logic KIND_END   = 1'b1;

  typedef struct packed {
    logic              record_kind;
    logic [ADDR_W-1:0] match_address;
    logic              found_any;
    logic              run_end;
  } rec_t;

  function automatic logic [7:0] pat_byte(input logic [63:0] lo, input logic [63:0] hi,
                                          input logic [BYTE_IDX_W-1:0] idx);
    logic [63:0] word;
    word = idx[BYTE_IDX_W-1] ? hi : lo;
    return word[idx[BYTE_IDX_W-2:0]*8 +: 8];
  endfunction

endpackage

`default_nettype wire

/* sv/mbps_in_if.sv */
// ----------------------------------------------------------------------------
// mbps_in_if
// Byte stream channel: one region byte and its last-byte flag per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface mbps_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

/* sv/mbps_out_if.sv */
// ----------------------------------------------------------------------------
// mbps_out_if
// Record channel: one match or end-of-region record per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface mbps_out_if;
  logic                      valid;
  logic                      ready;
  logic                      record_kind;
  logic [mbps_pkg::ADDR_W-1:0] match_address;
  logic                      found_any;
  logic                      run_end;

  modport source (output valid, output record_kind, output match_address,
                  output found_any, output run_end, input ready);
  modport sink   (input valid, input record_kind, input match_address,
                  input found_any, input run_end, output ready);
endinterface

`default_nettype wire

/* sv/mbps_cfg_if.sv */
// ----------------------------------------------------------------------------
// mbps_cfg_if
// Register write channel: register index and write data per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface mbps_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [mbps_pkg::CFG_IDX_W-1:0] index;
  logic [63:0]                    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* sv/mbps_cell.sv */
// ----------------------------------------------------------------------------
// mbps_cell
// One window byte: shifts in its neighbor's byte and tests it against the
// pattern byte aligned to its position.
// ----------------------------------------------------------------------------
`default_nettype none

module mbps_cell (
  input  wire logic       clk,
  input  wire logic       shift_en,
  input  wire logic [7:0] byte_in,
  input  wire logic       use_en,
  input  wire logic [7:0] mask,
  input  wire logic [7:0] value,
  output logic [7:0]      byte_out,
  output logic            hit
);

  logic [7:0] byte_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= byte_in;
    end
  end

  assign byte_out = byte_r;
  assign hit      = !use_en || ((byte_r & mask) == value);

endmodule

`default_nettype wire

/* sv/mbps_outq.sv */
// ----------------------------------------------------------------------------
// mbps_outq
// Two-entry record queue in front of the result channel; takes up to two
// records per cycle while the head drains.
// ----------------------------------------------------------------------------
`default_nettype none

module mbps_outq (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [1:0]    push_cnt,
  input  wire mbps_pkg::rec_t rec0,
  input  wire mbps_pkg::rec_t rec1,
  input  wire logic          pop,
  output logic [1:0]         room,
  output logic               head_valid,
  output mbps_pkg::rec_t     head
);
  import mbps_pkg::*;

  rec_t       ent_r   [2];
  rec_t       ent_nxt [2];
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;

  always_comb begin
    logic [1:0] c;
    c          = cnt_r;
    ent_nxt[0] = ent_r[0];
    ent_nxt[1] = ent_r[1];
    if (pop) begin
      ent_nxt[0] = ent_r[1];
      c          = c - 2'd1;
    end
    if (push_cnt == 2'd2) begin
      ent_nxt[0] = rec0;
      ent_nxt[1] = rec1;
    end else if (push_cnt == 2'd1) begin
      ent_nxt[c[0]] = rec0;
    end
    cnt_nxt = c + push_cnt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r[0] <= ent_nxt[0];
    ent_r[1] <= ent_nxt[1];
  end

  assign room       = 2'd2 - cnt_r + {1'b0, pop};
  assign head_valid = (cnt_r != 2'd0);
  assign head       = ent_r[0];

  ap_cnt_bound : assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("record queue over depth");

  ap_push_fits : assert property (@(posedge clk) disable iff (!rst_n)
    push_cnt <= room)
    else $error("record push without room");

  ap_pop_valid : assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("record pop from empty queue");

endmodule

`default_nettype wire

/* sv/masked_byte_pattern_scanner_unit.sv */
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner_unit
// Scans a byte stream for a masked byte pattern and reports match addresses.
//
// in_ch carries one region byte per transfer; last_byte marks the region's
// final byte. out_ch carries records: a match record with base address plus
// start offset of each matching window, and an end record with found_any on
// the region's last byte (match record first when both occur). cfg_ch writes
// the pattern, length and base registers and is always ready; write it only
// while no item is in flight.
// Throughput is one byte per cycle while the record queue has room; a byte
// that gives two records needs two output transfers. A record reaches out_ch
// through the registered window cells and then the registered record queue.
// The window is a row of byte cells shifting once per accepted byte, each
// cell comparing its byte with the pattern byte aligned to its place.
// Reset clears value, mask and base, sets length to one and clears the byte
// count, found flag and record queue; no clearing pass is needed. When out_ch
// stalls the two-entry record queue fills and in_ch.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module masked_byte_pattern_scanner_unit #(
  parameter int unsigned MAX_PATTERN_BYTES = mbps_pkg::MAX_PATTERN_BYTES_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  mbps_in_if.sink     in_ch,
  mbps_out_if.source  out_ch,
  mbps_cfg_if.sink    cfg_ch
);
  import mbps_pkg::*;

  logic [63:0]       value_lo_r;
  logic [63:0]       value_hi_r;
  logic [63:0]       mask_lo_r;
  logic [63:0]       mask_hi_r;
  logic [LEN_W-1:0]  length_r;
  logic [ADDR_W-1:0] base_r;

  logic              s1_v_r;
  logic              s1_last_r;
  logic [63:0]       seen_r;
  logic              clr_r;
  logic              found_r;

  logic [LEN_W-1:0]  len_u;
  logic              in_xfer;
  logic              seen_ok;
  logic              all_hit;
  logic              match;
  logic [1:0]        need;
  logic [1:0]        room;
  logic              fits;
  logic              s1_adv;
  logic [1:0]        push_cnt;
  logic              pop;
  logic              head_valid;
  logic [ADDR_W-1:0] addr;
  rec_t              rec0;
  rec_t              rec1;
  rec_t              head;
  rec_t              end_rec;

  logic [7:0]                   win  [MAX_PATTERN_BYTES];
  logic [MAX_PATTERN_BYTES-1:0] hits;

  // configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_lo_r <= '0;
      value_hi_r <= '0;
      mask_lo_r  <= '0;
      mask_hi_r  <= '0;
      length_r   <= LEN_W'(1);
      base_r     <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_VALUE_LO: value_lo_r <= cfg_ch.data;
        REG_VALUE_HI: value_hi_r <= cfg_ch.data;
        REG_MASK_LO:  mask_lo_r  <= cfg_ch.data;
        REG_MASK_HI:  mask_hi_r  <= cfg_ch.data;
        REG_LENGTH:   length_r   <= cfg_ch.data[LEN_W-1:0];
        REG_BASE:     base_r     <= cfg_ch.data;
        default:      ;
      endcase
    end
  end

  // clamp length into 1..MAX_PATTERN_BYTES
  always_comb begin
    len_u = length_r;
    if (length_r == '0) begin
      len_u = LEN_W'(1);
    end else if (length_r > LEN_W'(MAX_PATTERN_BYTES)) begin
      len_u = LEN_W'(MAX_PATTERN_BYTES);
    end
  end

  assign in_xfer = in_ch.valid && in_ch.ready;

  // window cells, cell 0 holds the newest byte
  for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cell
    localparam logic [LEN_W-1:0] K = LEN_W'(k);
    logic              use_en;
    logic [LEN_W-1:0]  idx_full;
    logic [BYTE_IDX_W-1:0] idx;
    logic [7:0]        byte_in;

    assign use_en   = K < len_u;
    assign idx_full = len_u - K - LEN_W'(1);
    assign idx      = idx_full[BYTE_IDX_W-1:0];

    if (k == 0) begin : g_head
      assign byte_in = in_ch.data_byte;
    end else begin : g_tail
      assign byte_in = win[k-1];
    end

    mbps_cell u_cell (
      .clk      (clk),
      .shift_en (in_xfer),
      .byte_in  (byte_in),
      .use_en   (use_en),
      .mask     (pat_byte(mask_lo_r, mask_hi_r, idx)),
      .value    (pat_byte(value_lo_r, value_hi_r, idx)),
      .byte_out (win[k]),
      .hit      (hits[k])
    );
  end

  // record formation for the byte now in the window
  assign seen_ok = (seen_r[63:LEN_W] != '0) || (seen_r[LEN_W-1:0] >= len_u);
  assign all_hit = &hits;
  assign match   = s1_v_r && seen_ok && all_hit;
  assign need    = {1'b0, match} + {1'b0, s1_v_r && s1_last_r};
  assign addr    = base_r + seen_r - {{(ADDR_W-LEN_W){1'b0}}, len_u};
  assign fits    = (need <= room);
  assign s1_adv  = s1_v_r && fits;

  assign in_ch.ready = !s1_v_r || fits;

  always_comb begin
    end_rec.record_kind   = KIND_END;
    end_rec.match_address = '0;
    end_rec.found_any     = found_r || match;
    end_rec.run_end       = 1'b1;
    rec1                  = end_rec;
    if (match) begin
      rec0.record_kind   = KIND_MATCH;
      rec0.match_address = addr;
      rec0.found_any     = 1'b0;
      rec0.run_end       = !s1_last_r;
    end else begin
      rec0 = end_rec;
    end
  end

  assign push_cnt = s1_adv ? need : 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      s1_last_r <= 1'b0;
      seen_r    <= '0;
      clr_r     <= 1'b0;
      found_r   <= 1'b0;
    end else begin
      if (in_xfer) begin
        s1_v_r    <= 1'b1;
        s1_last_r <= in_ch.last_byte;
        seen_r    <= (clr_r ? 64'd0 : seen_r) + 64'd1;
        clr_r     <= in_ch.last_byte;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        found_r <= s1_last_r ? 1'b0 : (found_r || match);
      end
    end
  end

  assign pop = out_ch.valid && out_ch.ready;

  mbps_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_cnt   (push_cnt),
    .rec0       (rec0),
    .rec1       (rec1),
    .pop        (pop),
    .room       (room),
    .head_valid (head_valid),
    .head       (head)
  );

  assign out_ch.valid         = head_valid;
  assign out_ch.record_kind   = head.record_kind;
  assign out_ch.match_address = head.match_address;
  assign out_ch.found_any     = head.found_any;
  assign out_ch.run_end       = head.run_end;

  ap_pending_drains : assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && s1_v_r) |-> s1_adv)
    else $error("byte shifted over an unrecorded window");

  ap_last_clears : assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_ch.last_byte) |=> clr_r)
    else $error("region end not marked for clearing");

  ap_found_tracks : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && match && !s1_last_r) |=> found_r)
    else $error("found flag missed a match");

  ap_end_addr_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.record_kind == KIND_END) |-> out_ch.match_address == '0)
    else $error("end record with nonzero address");

endmodule

`default_nettype wire

/* test/tb_masked_byte_pattern_scanner_unit.sv */
// ----------------------------------------------------------------------------
// tb_masked_byte_pattern_scanner_unit
// Streams byte regions through the scanner under several pattern settings and
// compares every match and end-of-region record with a local prediction of
// window contents, byte count and found flag. Both channels idle at random.
// ----------------------------------------------------------------------------

class byte_scan_scoreboard;
  logic [63:0] value_lo, value_hi, mask_lo, mask_hi, base;
  logic [mbps_pkg::LEN_W-1:0] length;
  logic [7:0]  window [16];
  logic [63:0] seen;
  bit          found;
  mbps_pkg::rec_t expected_records[$];
  int          errors;

  function new();
    value_lo = '0;
    value_hi = '0;
    mask_lo  = '0;
    mask_hi  = '0;
    base     = '0;
    length   = 1;
    errors   = 0;
    clear_region();
  endfunction

  function void clear_region();
    foreach (window[i]) window[i] = 8'h00;
    seen  = '0;
    found = 1'b0;
  endfunction

  function void set_register(logic [mbps_pkg::CFG_IDX_W-1:0] idx, logic [63:0] data);
    case (idx)
      mbps_pkg::REG_VALUE_LO: value_lo = data;
      mbps_pkg::REG_VALUE_HI: value_hi = data;
      mbps_pkg::REG_MASK_LO:  mask_lo  = data;
      mbps_pkg::REG_MASK_HI:  mask_hi  = data;
      mbps_pkg::REG_LENGTH:   length   = data[mbps_pkg::LEN_W-1:0];
      mbps_pkg::REG_BASE:     base     = data;
      default: ;
    endcase
  endfunction

  function int unsigned eff_length();
    if (length == 0) return 1;
    if (length > 16) return 16;
    return length;
  endfunction

  function logic [7:0] field_byte(logic [63:0] lo, logic [63:0] hi, int unsigned i);
    logic [63:0] word;
    word = (i < 8) ? lo : hi;
    return word[(i % 8) * 8 +: 8];
  endfunction

  function void note_byte(logic [7:0] d, logic last);
    int unsigned    len;
    bit             hit;
    mbps_pkg::rec_t rec;
    len = eff_length();
    for (int i = 15; i > 0; i--) window[i] = window[i-1];
    window[0] = d;
    seen = seen + 64'd1;
    hit = 1'b0;
    if (seen >= 64'(len)) begin
      hit = 1'b1;
      for (int unsigned i = 0; i < len; i++) begin
        if ((window[len-1-i] & field_byte(mask_lo, mask_hi, i)) !=
            field_byte(value_lo, value_hi, i))
          hit = 1'b0;
      end
    end
    if (hit) begin
      found = 1'b1;
      rec.record_kind   = mbps_pkg::KIND_MATCH;
      rec.match_address = base + (seen - 64'(len));
      rec.found_any     = 1'b0;
      rec.run_end       = !last;
      expected_records  = {expected_records, rec};
    end
    if (last) begin
      rec.record_kind   = mbps_pkg::KIND_END;
      rec.match_address = '0;
      rec.found_any     = found;
      rec.run_end       = 1'b1;
      expected_records  = {expected_records, rec};
      clear_region();
    end
  endfunction

  function void check_record(mbps_pkg::rec_t got);
    mbps_pkg::rec_t want;
    if (expected_records.size() == 0) begin
      $error("unexpected record: kind %0d address %0h", got.record_kind, got.match_address);
      errors++;
      return;
    end
    want = expected_records.pop_front();
    if (got.record_kind !== want.record_kind) begin
      $error("record_kind: expected %0h actual %0h", want.record_kind, got.record_kind);
      errors++;
    end
    if (got.match_address !== want.match_address) begin
      $error("match_address: expected %0h actual %0h", want.match_address, got.match_address);
      errors++;
    end
    if (got.found_any !== want.found_any) begin
      $error("found_any: expected %0h actual %0h", want.found_any, got.found_any);
      errors++;
    end
    if (got.run_end !== want.run_end) begin
      $error("run_end: expected %0h actual %0h", want.run_end, got.run_end);
      errors++;
    end
  endfunction
endclass

module tb_masked_byte_pattern_scanner_unit;
  import mbps_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
  localparam int STALL_LIMIT = 3000;
  localparam int PHASES      = 8;
  localparam int PHASE_BYTES = 68;

  logic clk;
  logic rst_n;
  bit   in_steady;
  bit   out_steady;
  int   idle_cycles;

  mbps_in_if  in_ch();
  mbps_out_if out_ch();
  mbps_cfg_if cfg_ch();

  byte_scan_scoreboard sb = new();

  masked_byte_pattern_scanner_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned gap_len(bit steady);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // accepted transfers, record checks and watchdog
  always @(posedge clk) begin
    mbps_pkg::rec_t got;
    bit moved;
    moved = 1'b0;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.record_kind   = out_ch.record_kind;
        got.match_address = out_ch.match_address;
        got.found_any     = out_ch.found_any;
        got.run_end       = out_ch.run_end;
        sb.check_record(got);
        moved = 1'b1;
      end
      if (in_ch.valid && in_ch.ready) begin
        sb.note_byte(in_ch.data_byte, in_ch.last_byte);
        moved = 1'b1;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        sb.set_register(cfg_ch.index, cfg_ch.data);
        moved = 1'b1;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end else begin
      idle_cycles = 0;
    end
  end

  // result side backpressure
  initial begin
    out_ch.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (!out_steady && $urandom_range(0, 4) == 0) begin
        out_ch.ready = 1'b0;
        repeat (gap_len(1'b0) + 1) @(negedge clk);
        out_ch.ready = 1'b1;
      end
    end
  end

  task automatic send_byte(logic [7:0] d, logic last);
    int unsigned gap;
    gap = gap_len(in_steady);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.data_byte = d;
    in_ch.last_byte = last;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = val;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic wait_drained();
    in_ch.valid = 1'b0;
    while (sb.expected_records.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [7:0] random_data();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // pattern instances, partial prefixes and noise, regions closed at random
  task automatic send_traffic(int count);
    int unsigned len, k, r;
    logic [7:0]  v, m;
    int          sent;
    sent = 0;
    while (sent < count) begin
      len = sb.eff_length();
      r = $urandom_range(0, 99);
      if (r < 50) k = len;
      else if (r < 65) k = $urandom_range(1, len);
      else k = $urandom_range(1, 4);
      for (int unsigned i = 0; i < k; i++) begin
        v = sb.field_byte(sb.value_lo, sb.value_hi, i);
        m = sb.field_byte(sb.mask_lo, sb.mask_hi, i);
        if (r < 65) send_byte((v & m) | (8'($urandom) & ~m), $urandom_range(0, 15) == 0);
        else send_byte(random_data(), $urandom_range(0, 15) == 0);
        sent++;
      end
      if ($urandom_range(0, 199) == 0) wait_drained();
    end
  endtask

  function automatic logic [63:0] random_masks(int unsigned mode);
    logic [63:0] w;
    int unsigned r;
    for (int i = 0; i < 8; i++) begin
      r = $urandom_range(0, 99);
      if (mode == 1) w[i*8 +: 8] = 8'hFF;
      else if (mode == 2) w[i*8 +: 8] = 8'h00;
      else if (r < 20) w[i*8 +: 8] = 8'h00;
      else if (r < 70) w[i*8 +: 8] = 8'hFF;
      else w[i*8 +: 8] = 8'($urandom);
    end
    return w;
  endfunction

  function automatic logic [63:0] random_values(logic [63:0] masks, bit all_ones);
    logic [63:0] w;
    if (all_ones) return masks;
    w = {$urandom, $urandom};
    if ($urandom_range(0, 9) == 0) return w;
    return w & masks;
  endfunction

  initial begin
    logic [4:0]  phase_len [PHASES];
    logic [63:0] mlo, mhi, base;
    logic [CFG_IDX_W-1:0] order [6];
    int unsigned mode;

    phase_len = '{5'd2, 5'd16, 5'd0, 5'd31, 5'd4, 5'd17, 5'd1, 5'd8};
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.last_byte = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = REG_VALUE_LO;
    cfg_ch.data     = '0;
    in_steady       = 1'b0;
    out_steady      = 1'b0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // reset pattern: one wildcard byte, every byte matches
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hA5, 1'b1);
    send_byte(8'h5A, 1'b1);
    wait_drained();

    // four byte pattern with a wildcard, junk in unused bytes, address wrap
    write_register(REG_VALUE_LO, 64'hDEAD_BEEF_ABF0_0012);
    write_register(REG_MASK_LO,  64'hFFFF_FFFF_FFF0_00FF);
    write_register(REG_VALUE_HI, 64'hFFFF_FFFF_FFFF_FFFF);
    write_register(REG_MASK_HI,  64'hFFFF_FFFF_FFFF_FFFF);
    write_register(REG_LENGTH,   64'd4);
    write_register(REG_BASE,     64'hFFFF_FFFF_FFFF_FFFE);
    send_byte(8'h12, 1'b0);
    send_byte(8'h77, 1'b0);
    send_byte(8'hF5, 1'b0);
    send_byte(8'hAB, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h33, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'hAB, 1'b1);
    // region shorter than the pattern
    send_byte(8'h12, 1'b0);
    send_byte(8'h00, 1'b1);
    wait_drained();

    // zero length acts as one
    write_register(REG_LENGTH, 64'd0);
    write_register(REG_SPARE_A, {$urandom, $urandom});
    write_register(REG_SPARE_B, {$urandom, $urandom});
    send_byte(8'h12, 1'b1);
    send_byte(8'h13, 1'b1);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      in_steady  = ($urandom_range(0, 3) == 0);
      out_steady = ($urandom_range(0, 3) == 0);
      if (p % 3 == 2) begin
        // length only, the open region carries on
        write_register(REG_LENGTH, 64'(phase_len[p]));
      end else begin
        mode = (p == 0) ? 1 : (p == 4) ? 2 : 0;
        mlo  = random_masks(mode);
        mhi  = random_masks(mode);
        case ($urandom_range(0, 2))
          0: base = '0;
          1: base = '1;
          default: base = {$urandom, $urandom};
        endcase
        order = '{REG_VALUE_LO, REG_VALUE_HI, REG_MASK_LO, REG_MASK_HI, REG_LENGTH, REG_BASE};
        order.shuffle();
        foreach (order[i]) begin
          case (order[i])
            REG_VALUE_LO: write_register(REG_VALUE_LO, random_values(mlo, p == 0));
            REG_VALUE_HI: write_register(REG_VALUE_HI, random_values(mhi, p == 0));
            REG_MASK_LO:  write_register(REG_MASK_LO, mlo);
            REG_MASK_HI:  write_register(REG_MASK_HI, mhi);
            REG_LENGTH:   write_register(REG_LENGTH, 64'(phase_len[p]));
            default:      write_register(REG_BASE, base);
          endcase
        end
      end
      send_traffic(PHASE_BYTES);
      wait_drained();
    end

    in_ch.valid = 1'b0;
    while (sb.expected_records.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (sb.errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

/* sim.f */
sv/mbps_pkg.sv
sv/mbps_in_if.sv
sv/mbps_out_if.sv
sv/mbps_cfg_if.sv
sv/mbps_cell.sv
sv/mbps_outq.sv
sv/masked_byte_pattern_scanner_unit.sv
test/tb_masked_byte_pattern_scanner_unit.sv
